// File: hw/rtl/gpr_pkg.sv
// Shared types, register map and reset constants of the GPIO port register block.
`timescale 1ns / 1ps

package gpr_pkg;

	localparam int REG_COUNT_DEF = 10;
	localparam int PIN_COUNT_DEF = 16;

	// register map, word index
	localparam int IX_MODER   = 0;
	localparam int IX_OTYPER  = 1;
	localparam int IX_OSPEEDR = 2;
	localparam int IX_PUPDR   = 3;
	localparam int IX_IDR     = 4;
	localparam int IX_ODR     = 5;
	localparam int IX_BSRR    = 6;

	// configuration register indexes
	localparam logic CFG_IDR_CLEAR     = 1'b0;
	localparam logic CFG_RESET_PROFILE = 1'b1;

	// access sizes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	// reset profiles
	localparam logic [1:0] PROFILE_A0   = 2'd0;
	localparam logic [1:0] PROFILE_A1   = 2'd1;
	localparam logic [1:0] PROFILE_B    = 2'd2;
	localparam logic [1:0] PROFILE_ZERO = 2'd3;

	localparam logic [31:0] PROF_A_MODER   = 32'ha800_0000;
	localparam logic [31:0] PROF_A_PUPDR   = 32'h6400_0000;
	localparam logic [31:0] PROF_B_MODER   = 32'h0000_0280;
	localparam logic [31:0] PROF_B_OSPEEDR = 32'h0000_00C0;
	localparam logic [31:0] PROF_B_PUPDR   = 32'h0000_0100;
	localparam logic [15:0] IDR_RESET      = 16'hFFFF;

	// pin mode codes
	localparam logic [1:0] MODE_INPUT  = 2'd0;
	localparam logic [1:0] MODE_OUTPUT = 2'd1;
	localparam logic [1:0] MODE_ALT    = 2'd2;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_PIN   = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [3:0]  reg_index;
		logic [1:0]  byte_offset;
		logic [1:0]  access_size;
		logic [31:0] write_data;
		logic [3:0]  pin_index;
		logic        pin_level;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] pin_levels;
		logic [15:0] pins_changed;
		logic [15:0] alt_levels;
		logic [15:0] alt_changed;
		logic [3:0]  event_pin;
		logic        event_level;
		logic        access_error;
	} out_item_t;

endpackage

// File: hw/rtl/gpr_in_stage.sv
// Input register stage of the GPIO port register block.
`timescale 1ns / 1ps

module gpr_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gpr_pkg::in_item_t in_data,
	input  logic              advance,
	output logic              valid_s1,
	output gpr_pkg::in_item_t data_s1
);

	logic take;

	// hold while the item cannot move on to the result stage
	assign in_stall = valid_s1 & ~advance;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= in_data;
		end
	end

endmodule

// File: hw/rtl/gpr_core.sv
// Register file, configuration registers and per-command update logic.
`timescale 1ns / 1ps

module gpr_core #(
	parameter int REG_COUNT = gpr_pkg::REG_COUNT_DEF,
	parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               fire,
	input  gpr_pkg::in_item_t  item,
	output gpr_pkg::out_item_t result
);

	localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);
	localparam logic [4:0]  REG_LIM  = 5'(REG_COUNT);
	localparam logic [4:0]  PIN_LIM  = 5'(PIN_COUNT);

	logic [31:0] rf_q [REG_COUNT];
	logic [31:0] rf_n [REG_COUNT];
	logic [15:0] idr_clear_q;
	logic [1:0]  profile_q;

	logic        ix_ok;
	logic        pin_ok;
	logic [31:0] cur;
	logic [31:0] lane_mask;
	logic [31:0] lane_data;
	logic        size_ok;
	logic [31:0] wval;
	logic [4:0]  shamt;
	logic [15:0] chg;
	logic [15:0] to_in;
	logic [15:0] to_out;
	logic [15:0] odr_old;
	logic [15:0] odr_new;
	logic [31:0] prof_moder;
	logic [31:0] prof_ospeedr;
	logic [31:0] prof_pupdr;
	logic [15:0] alt_chg;
	logic [31:0] rd;

	function automatic logic [15:0] mode_diff(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		logic [15:0] m;
		d = a ^ b;
		for (int i = 0; i < 16; i++) begin
			m[i] = |d[2*i +: 2];
		end
		return m & PIN_MASK;
	endfunction

	function automatic logic [15:0] mode_is(input logic [31:0] moder, input logic [1:0] code);
		logic [15:0] m;
		for (int i = 0; i < 16; i++) begin
			m[i] = (moder[2*i +: 2] == code);
		end
		return m & PIN_MASK;
	endfunction

	assign ix_ok  = {1'b0, item.reg_index} < REG_LIM;
	assign pin_ok = {1'b0, item.pin_index} < PIN_LIM;
	assign shamt  = {item.byte_offset, 3'b000};

	// addressed word
	always_comb begin
		cur = '0;
		for (int i = 0; i < REG_COUNT; i++) begin
			if (item.reg_index == 4'(i)) begin
				cur = rf_q[i];
			end
		end
	end

	// lane merge of narrow writes
	always_comb begin
		size_ok   = 1'b1;
		lane_mask = '0;
		lane_data = '0;
		unique case (item.access_size)
			gpr_pkg::SIZE_BYTE: begin
				lane_mask = 32'h0000_00FF << shamt;
				lane_data = (item.write_data & 32'h0000_00FF) << shamt;
			end
			gpr_pkg::SIZE_HALF: begin
				lane_mask = 32'h0000_FFFF << shamt;
				lane_data = (item.write_data & 32'h0000_FFFF) << shamt;
			end
			gpr_pkg::SIZE_WORD: begin
				lane_mask = 32'hFFFF_FFFF;
				lane_data = item.write_data;
			end
			default: begin
				size_ok = 1'b0;
			end
		endcase
	end

	assign wval = (cur & ~lane_mask) | lane_data;

	always_comb begin
		prof_moder   = '0;
		prof_ospeedr = '0;
		prof_pupdr   = '0;
		unique case (profile_q)
			gpr_pkg::PROFILE_A0, gpr_pkg::PROFILE_A1: begin
				prof_moder = gpr_pkg::PROF_A_MODER;
				prof_pupdr = gpr_pkg::PROF_A_PUPDR;
			end
			gpr_pkg::PROFILE_B: begin
				prof_moder   = gpr_pkg::PROF_B_MODER;
				prof_ospeedr = gpr_pkg::PROF_B_OSPEEDR;
				prof_pupdr   = gpr_pkg::PROF_B_PUPDR;
			end
			gpr_pkg::PROFILE_ZERO: begin
				prof_moder = '0;
			end
		endcase
	end

	assign odr_old = rf_q[gpr_pkg::IX_ODR][15:0];
	assign chg     = mode_diff(rf_q[gpr_pkg::IX_MODER], wval);
	assign to_in   = chg & mode_is(wval, gpr_pkg::MODE_INPUT) & ~odr_old;
	assign to_out  = chg & mode_is(wval, gpr_pkg::MODE_OUTPUT) & odr_old;

	always_comb begin
		for (int i = 0; i < REG_COUNT; i++) begin
			rf_n[i] = rf_q[i];
		end
		alt_chg = '0;
		rd      = '0;
		unique case (item.command)
			gpr_pkg::CMD_READ: begin
				if (ix_ok) begin
					rd = cur;
				end
			end
			gpr_pkg::CMD_WRITE: begin
				if (ix_ok && size_ok) begin
					priority if (item.reg_index == 4'(gpr_pkg::IX_MODER)) begin
						rf_n[gpr_pkg::IX_MODER] = wval;
						rf_n[gpr_pkg::IX_ODR]   = {16'h0, (odr_old | to_in) & ~to_out};
						rf_n[gpr_pkg::IX_IDR]   = rf_q[gpr_pkg::IX_IDR] | {16'h0, to_in};
						alt_chg                 = chg;
					end else if (item.reg_index == 4'(gpr_pkg::IX_ODR)) begin
						rf_n[gpr_pkg::IX_ODR] = {16'h0, wval[15:0]};
					end else if (item.reg_index == 4'(gpr_pkg::IX_BSRR)) begin
						// clear then set; the register itself keeps nothing
						rf_n[gpr_pkg::IX_IDR] = (rf_q[gpr_pkg::IX_IDR] & ~{16'h0, wval[31:16]})
							| {16'h0, wval[15:0]};
						rf_n[gpr_pkg::IX_ODR] = {16'h0, (odr_old & ~wval[31:16]) | wval[15:0]};
					end else begin
						for (int i = 0; i < REG_COUNT; i++) begin
							if (item.reg_index == 4'(i)) begin
								rf_n[i] = wval;
							end
						end
					end
				end
			end
			gpr_pkg::CMD_PIN: begin
				if (pin_ok) begin
					rf_n[gpr_pkg::IX_IDR][{1'b0, item.pin_index}] = item.pin_level;
				end
			end
			gpr_pkg::CMD_RESET: begin
				rf_n[gpr_pkg::IX_MODER]   = prof_moder;
				rf_n[gpr_pkg::IX_OSPEEDR] = prof_ospeedr;
				rf_n[gpr_pkg::IX_PUPDR]   = prof_pupdr;
				rf_n[gpr_pkg::IX_IDR]     = {16'h0, gpr_pkg::IDR_RESET & ~idr_clear_q};
				alt_chg = mode_diff(rf_q[gpr_pkg::IX_MODER], prof_moder);
			end
		endcase
	end

	assign odr_new = rf_n[gpr_pkg::IX_ODR][15:0];

	always_comb begin
		result.read_data    = rd;
		result.pin_levels   = odr_new;
		result.pins_changed = (odr_old ^ odr_new) & PIN_MASK;
		result.alt_levels   = mode_is(rf_n[gpr_pkg::IX_MODER], gpr_pkg::MODE_ALT);
		result.alt_changed  = alt_chg;
		result.event_pin    = (item.command == gpr_pkg::CMD_PIN && pin_ok) ? item.pin_index : 4'd0;
		result.event_level  = (item.command == gpr_pkg::CMD_PIN && pin_ok) ? item.pin_level : 1'b0;
		result.access_error = (item.command == gpr_pkg::CMD_READ
			|| item.command == gpr_pkg::CMD_WRITE) && !ix_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idr_clear_q <= '0;
			profile_q   <= gpr_pkg::PROFILE_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpr_pkg::CFG_IDR_CLEAR:     idr_clear_q <= cfg_data;
				gpr_pkg::CFG_RESET_PROFILE: profile_q   <= cfg_data[1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
			rf_q[gpr_pkg::IX_IDR] <= {16'h0, gpr_pkg::IDR_RESET};
		end else if (fire) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= rf_n[i];
			end
		end
	end

endmodule

// File: hw/rtl/gpio_port_register_block.sv
// Top level of the GPIO port register block: handshake control and result register.
// Path: an accepted item goes through the input register and then the result register.
// Throughput: one item per cycle unless out_stall holds a full result register; all
// per-pin work is bitwise logic in a single pass.
// A full result register under stall still lets one more item into the input register.
// Reset: MODER, OSPEEDR, PUPDR, OTYPER and the rest clear, IDR loads 0000ffff,
// the IDR clear mask clears and reset_profile selects the all-zero profile.
`timescale 1ns / 1ps

module gpio_port_register_block #(
	parameter int REG_COUNT = gpr_pkg::REG_COUNT_DEF,
	parameter int PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  gpr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output gpr_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	logic               valid_s1;
	gpr_pkg::in_item_t  data_s1;
	logic               advance;
	gpr_pkg::out_item_t result;
	logic               out_valid_q;
	gpr_pkg::out_item_t out_data_q;

	assign cfg_ready = 1'b1;

	// advance when the result register is empty or its transfer completes now
	assign advance = valid_s1 & (~out_valid_q | ~out_stall);

	gpr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	gpr_core #(
		.REG_COUNT (REG_COUNT),
		.PIN_COUNT (PIN_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (advance),
		.item      (data_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
